[rtl/htfd_pkg.sv]
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and functions for the humidity/temperature frame
// decoder: frame positions, CRC-8 step, scaling constants and the job record.
// ----------------------------------------------------------------------------
package htfd_pkg;

  // crc-8, polynomial x^8+x^5+x^4+1, msb first
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // output field widths
  localparam int TEMP_W  = 15;
  localparam int HUMID_W = 14;

  // scaling constants
  localparam logic [14:0] TEMP_SPAN   = 15'd17500;
  localparam logic [13:0] HUMID_SPAN  = 14'd10000;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [16:0] RAW_FULL    = 17'd65535;

  // product widths: span * 16-bit raw word
  localparam int TPROD_W = 31;
  localparam int HPROD_W = 30;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  // byte position inside a frame
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // one finished frame handed from front to back
  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] humid_word;
    logic        ok;
  } job_t;

  // front to queue push request
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // one crc byte step, eight shift steps
  function automatic logic [7:0] crc_mix(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^32 with high half below 65535:
  // x = 65535*hi + (hi + lo), and hi + lo stays under twice the divisor
  function automatic logic [15:0] div_raw_full(input logic [31:0] x);
    logic [16:0] s;
    s = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    return x[31:16] + {15'd0, (s >= RAW_FULL)};
  endfunction

endpackage

[rtl/htfd_front.sv]
// ----------------------------------------------------------------------------
// htfd_front
// Accepts frame bytes, tracks the byte position, runs the crc and assembles
// the raw words; pushes one job into the queue per completed frame.
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [7:0]     in_byte,
  input  logic           in_start,
  output logic           in_ready,
  input  logic           q_full,
  output htfd_pkg::push_t push
);
  import htfd_pkg::*;

  pos_t        pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic        temp_good_r, temp_good_nxt;
  logic [15:0] humid_word_r, humid_word_nxt;
  pos_t        pos_eff;
  logic        accept;

  // take a byte whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // start flag or an impossible position restarts the frame
  assign pos_eff = (in_start || (pos_r > POS_H_CRC)) ? POS_T_HI : pos_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_T_HI;
      crc_r        <= CRC_INIT;
      temp_word_r  <= '0;
      temp_good_r  <= 1'b0;
      humid_word_r <= '0;
    end else begin
      pos_r        <= pos_nxt;
      crc_r        <= crc_nxt;
      temp_word_r  <= temp_word_nxt;
      temp_good_r  <= temp_good_nxt;
      humid_word_r <= humid_word_nxt;
    end
  end

  // per-byte update and job push
  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    temp_word_nxt  = temp_word_r;
    temp_good_nxt  = temp_good_r;
    humid_word_nxt = humid_word_r;
    push.valid     = 1'b0;
    push.job.temp_word  = temp_word_r;
    push.job.humid_word = humid_word_r;
    push.job.ok         = temp_good_r && (in_byte == crc_r);
    if (accept) begin
      unique case (pos_eff)
        POS_T_HI: begin
          crc_nxt       = crc_mix(CRC_INIT, in_byte);
          temp_word_nxt = {in_byte, 8'd0};
          pos_nxt       = POS_T_LO;
        end
        POS_T_LO: begin
          crc_nxt       = crc_mix(crc_r, in_byte);
          temp_word_nxt = {temp_word_r[15:8], in_byte};
          pos_nxt       = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_good_nxt = (in_byte == crc_r);
          crc_nxt       = CRC_INIT;
          pos_nxt       = POS_H_HI;
        end
        POS_H_HI: begin
          crc_nxt        = crc_mix(CRC_INIT, in_byte);
          humid_word_nxt = {in_byte, 8'd0};
          pos_nxt        = POS_H_LO;
        end
        POS_H_LO: begin
          crc_nxt        = crc_mix(crc_r, in_byte);
          humid_word_nxt = {humid_word_r[15:8], in_byte};
          pos_nxt        = POS_H_CRC;
        end
        default: begin
          crc_nxt    = CRC_INIT;
          pos_nxt    = POS_T_HI;
          push.valid = 1'b1;
        end
      endcase
    end
  end

endmodule

[rtl/htfd_queue.sv]
// ----------------------------------------------------------------------------
// htfd_queue
// Short first-in first-out queue of finished frames between front and back.
// ----------------------------------------------------------------------------
module htfd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  htfd_pkg::push_t push,
  output logic            full,
  output logic            pop_valid,
  output htfd_pkg::job_t  pop_job,
  input  logic            pop
);
  import htfd_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full      = (count_r == CW'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_job   = slot_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push.valid, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.job;
    end
  end

endmodule

[rtl/htfd_back.sv]
// ----------------------------------------------------------------------------
// htfd_back
// Scales the raw words of one job: constant multiply stage, then division by
// 65535 and offset into the output register.
// ----------------------------------------------------------------------------
module htfd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_valid,
  input  htfd_pkg::job_t                 job,
  output logic                           job_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [htfd_pkg::TEMP_W-1:0] out_temp,
  output logic [htfd_pkg::HUMID_W-1:0]   out_humid,
  output logic                           out_ok
);
  import htfd_pkg::*;

  logic               s1_valid_r;
  logic [TPROD_W-1:0] s1_tprod_r;
  logic [HPROD_W-1:0] s1_hprod_r;
  logic               s1_ok_r;
  logic               s2_valid_r;
  logic [TEMP_W-1:0]  s2_temp_r, s2_temp_nxt;
  logic [HUMID_W-1:0] s2_humid_r, s2_humid_nxt;
  logic               s2_ok_r;
  logic               s2_load;
  logic               s1_load;
  logic [31:0]        tprod_full;
  logic [31:0]        hprod_full;
  logic [15:0]        t_q;
  logic [15:0]        h_q;
  logic [15:0]        t_off;

  // stall chain from the output back to the queue
  assign s2_load = !s2_valid_r || out_ready;
  assign s1_load = !s1_valid_r || s2_load;
  assign job_pop = job_valid && s1_load;

  // stage 1: constant multiplies
  assign tprod_full = 32'(job.temp_word) * 32'(TEMP_SPAN);
  assign hprod_full = 32'(job.humid_word) * 32'(HUMID_SPAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      s1_tprod_r <= tprod_full[TPROD_W-1:0];
      s1_hprod_r <= hprod_full[HPROD_W-1:0];
      s1_ok_r    <= job.ok;
    end
  end

  // stage 2: divide by full scale, apply offset, zero on crc failure
  always_comb begin
    t_q          = div_raw_full(32'(s1_tprod_r));
    h_q          = div_raw_full(32'(s1_hprod_r));
    t_off        = t_q - TEMP_OFFSET;
    s2_temp_nxt  = s1_ok_r ? t_off[TEMP_W-1:0] : '0;
    s2_humid_nxt = s1_ok_r ? h_q[HUMID_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_temp_r  <= s2_temp_nxt;
      s2_humid_r <= s2_humid_nxt;
      s2_ok_r    <= s1_ok_r;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_temp  = s2_temp_r;
  assign out_humid = s2_humid_r;
  assign out_ok    = s2_ok_r;

endmodule

[rtl/humidity_temp_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_unit
// Decodes six-byte humidity/temperature measurement frames with two crc-8
// checks and emits scaled readings in hundredths.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per item, in_tuser set on the first byte of a
//           frame. Frame order: temp hi, temp lo, temp crc, humid hi,
//           humid lo, humid crc.
//   out_* : one result per completed frame; tdata carries temperature
//           (signed, bits 14:0) and humidity (bits 28:15), tuser is crc_ok.
//           On a crc mismatch both values are zero.
//   Throughput: one byte per cycle while in_tready is high. The front runs
//   the crc step in the cycle a byte is taken; the back takes a new frame
//   while the previous one is still in its stages. The job of the sixth
//   byte passes the queue, one multiply stage and one divide-and-offset stage.
//   Stall: a stalled output holds its result; one more finished frame waits
//   in the multiply stage and up to two in the queue, and in_tready drops
//   only when the queue is full.
//   Reset: synchronous, active low; clears the frame position (next byte is a
//   first byte), the crc, the queue and all valid flags.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi
  output logic        out_tuser   // [0] crc_ok
);
  import htfd_pkg::*;

  push_t                     push;
  logic                      q_full;
  logic                      q_valid;
  job_t                      q_job;
  logic                      q_pop;
  logic signed [TEMP_W-1:0]  temp_centi;
  logic [HUMID_W-1:0]        humid_centi;
  logic                      crc_ok;

  // byte intake and crc
  htfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_byte  (in_tdata),
    .in_start (in_tuser),
    .in_ready (in_tready),
    .q_full   (q_full),
    .push     (push)
  );

  // finished frame queue
  htfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_job   (q_job),
    .pop       (q_pop)
  );

  // scaling pipeline
  htfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_temp  (temp_centi),
    .out_humid (humid_centi),
    .out_ok    (crc_ok)
  );

  // output packing
  assign out_tdata = {3'd0, humid_centi, temp_centi};
  assign out_tuser = crc_ok;

  // a frame never completes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !q_full)
    else $error("frame pushed into full queue");

  // failed frames carry zero readings
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0))
    else $error("nonzero readings on crc failure");

  // good temperature stays within the sensor range
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ((temp_centi >= -15'sd4500) && (temp_centi <= 15'sd13000)))
    else $error("temperature out of range");

  // good humidity stays within 0 to 100 percent
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (humid_centi <= 14'd10000))
    else $error("humidity out of range");

endmodule

[verif/tb_humidity_temp_frame_decoder_unit.sv]
// ----------------------------------------------------------------------------
// tb_humidity_temp_frame_decoder_unit
// Self-checking bench for the frame decoder: streams six-byte measurement
// frames (good, with spoiled checksums, cut short by a new start, or plain
// noise bytes), predicts every reading from its own frame tracker and
// compares each output item with the oldest pending reading.
// ----------------------------------------------------------------------------

// frame tracker and pending readings
class frame_scoreboard;

  typedef struct packed {
    logic [14:0] temp;
    logic [13:0] humid;
    logic        ok;
  } reading_t;

  htfd_pkg::pos_t slot;
  logic [7:0]     crc;
  logic [15:0]    temp_raw;
  logic [15:0]    humid_raw;
  logic           temp_good;
  reading_t       readings[$];
  int             mismatches;

  function new();
    slot       = htfd_pkg::POS_T_HI;
    crc        = htfd_pkg::CRC_INIT;
    temp_raw   = '0;
    humid_raw  = '0;
    temp_good  = 1'b0;
    mismatches = 0;
  endfunction

  // crc-8 over one byte, msb first
  function logic [7:0] fold_crc(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    repeat (8) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // track one accepted byte, queue a reading at the end of a frame
  function void note_byte(input logic [7:0] b, input logic first);
    htfd_pkg::pos_t p;
    reading_t       r;
    int             t_scaled;
    int             h_scaled;
    p = first ? htfd_pkg::POS_T_HI : slot;
    case (p)
      htfd_pkg::POS_T_HI: begin
        crc      = fold_crc(htfd_pkg::CRC_INIT, b);
        temp_raw = {b, 8'h00};
      end
      htfd_pkg::POS_T_LO: begin
        crc      = fold_crc(crc, b);
        temp_raw = {temp_raw[15:8], b};
      end
      htfd_pkg::POS_T_CRC: begin
        temp_good = (b == crc);
        crc       = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_H_HI: begin
        crc       = fold_crc(htfd_pkg::CRC_INIT, b);
        humid_raw = {b, 8'h00};
      end
      htfd_pkg::POS_H_LO: begin
        crc       = fold_crc(crc, b);
        humid_raw = {humid_raw[15:8], b};
      end
      default: begin
        r = '0;
        if (temp_good && b == crc) begin
          t_scaled = int'(htfd_pkg::TEMP_SPAN) * int'(temp_raw) / int'(htfd_pkg::RAW_FULL)
                     - int'(htfd_pkg::TEMP_OFFSET);
          h_scaled = int'(htfd_pkg::HUMID_SPAN) * int'(humid_raw)
                     / int'(htfd_pkg::RAW_FULL);
          r.temp  = t_scaled[14:0];
          r.humid = h_scaled[13:0];
          r.ok    = 1'b1;
        end
        readings.push_back(r);
        crc  = htfd_pkg::CRC_INIT;
        slot = htfd_pkg::POS_T_HI;
        return;
      end
    endcase
    slot = htfd_pkg::pos_t'(p + 3'd1);
  endfunction

  function void flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  // compare one output item with the oldest pending reading
  function void check_result(input logic [31:0] data, input logic flag);
    reading_t r;
    if (readings.size() == 0) begin
      flag_mismatch($sformatf("unexpected item temp %0d humid %0d ok %b",
                              $signed(data[14:0]), data[28:15], flag));
      return;
    end
    r = readings.pop_front();
    if (data[14:0] !== r.temp || data[28:15] !== r.humid || flag !== r.ok ||
        data[31:29] !== 3'b000) begin
      flag_mismatch($sformatf("exp temp %0d humid %0d ok %b, got temp %0d humid %0d ok %b pad %b",
                              $signed(r.temp), r.humid, r.ok,
                              $signed(data[14:0]), data[28:15], flag, data[31:29]));
    end
  endfunction

  // readings never delivered count as failures
  function void close_out();
    while (readings.size() != 0) begin
      void'(readings.pop_front());
      flag_mismatch("reading never delivered");
    end
  endfunction

endclass

module tb_humidity_temp_frame_decoder_unit;

  localparam int STALL_LIMIT = 2000;
  localparam int BYTE_TARGET = 1150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] rx_byte
  logic        in_tuser = 1'b0;    // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [14:0] temperature_centi, [28:15] humidity_centi
  logic        out_tuser;          // [0] crc_ok

  frame_scoreboard sb = new();
  int   bytes_sent = 0;
  int   stall_cycles = 0;
  logic calm = 1'b0;

  humidity_temp_frame_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // receiver back-pressure, none during the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 37);
    end
  end

  // item monitor on both channels
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("humidity_temp_frame_decoder_unit regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one byte through the input handshake, random gaps outside the calm stretch
  task automatic send_byte(input logic [7:0] b, input logic first);
    calm = (bytes_sent >= 500 && bytes_sent < 700);
    while (!calm && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // full frame, spoil[0] breaks the temperature crc, spoil[1] the humidity crc
  task automatic send_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                            input logic mark, input logic [1:0] spoil);
    logic [7:0] t_crc;
    logic [7:0] h_crc;
    t_crc = sb.fold_crc(sb.fold_crc(htfd_pkg::CRC_INIT, t_raw[15:8]), t_raw[7:0]);
    h_crc = sb.fold_crc(sb.fold_crc(htfd_pkg::CRC_INIT, h_raw[15:8]), h_raw[7:0]);
    if (spoil[0]) t_crc ^= 8'($urandom_range(255, 1));
    if (spoil[1]) h_crc ^= 8'($urandom_range(255, 1));
    send_byte(t_raw[15:8], mark);
    send_byte(t_raw[7:0], 1'b0);
    send_byte(t_crc, 1'b0);
    send_byte(h_raw[15:8], 1'b0);
    send_byte(h_raw[7:0], 1'b0);
    send_byte(h_crc, 1'b0);
  endtask

  // raw word, now and then one of the edge values
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(19))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int kind;
    int cut;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: range ends, wrap without start, cut frame, bad checksums
    send_frame(16'h0000, 16'hFFFF, 1'b1, 2'b00);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 2'b00);
    send_byte(8'h66, 1'b1);
    send_byte(8'h99, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b1, 2'b10);
    send_frame(16'h1234, 16'hABCD, 1'b1, 2'b01);

    // random: mostly frames, some cut short, some noise bytes
    while (bytes_sent < BYTE_TARGET) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        send_frame(pick_raw(), pick_raw(), $urandom_range(3) != 0,
                   ($urandom_range(99) < 15) ? 2'($urandom_range(3, 1)) : 2'b00);
      end else if (kind < 88) begin
        cut = $urandom_range(5, 1);
        send_byte(8'($urandom), 1'b1);
        repeat (cut - 1) send_byte(8'($urandom), 1'b0);
      end else begin
        send_byte(8'($urandom), 1'($urandom));
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    // drain, then a few cycles for any stray item
    while (sb.readings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("humidity_temp_frame_decoder_unit regression: pass");
    end else begin
      $display("humidity_temp_frame_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule
